@@ hdl/qgsu_pkg.sv @@
// Package for the single-qubit gate state update block.
// Command codes, status codes, register indexes and payload structs.
package qgsu_pkg;
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_GATE  = 2'd2,
    CMD_CGATE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_QB  = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  localparam logic [2:0] REG_M00   = 3'd0;
  localparam logic [2:0] REG_M01   = 3'd1;
  localparam logic [2:0] REG_M10   = 3'd2;
  localparam logic [2:0] REG_M11   = 3'd3;
  localparam logic [2:0] REG_QUBIT = 3'd4;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [9:0]   amp_index;
    logic signed [15:0] write_real;
    logic signed [15:0] write_imag;
    logic [3:0]   target_bit;
    logic [3:0]   control_bit;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] read_real;
    logic signed [15:0] read_imag;
    logic [1:0]   status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        fail;
    logic [1:0]  status;
    logic [19:0] index;
    logic [15:0] wr_re;
    logic [15:0] wr_im;
    logic [4:0]  tb;
    logic [4:0]  cb;
    logic        ctrl;
  } work_t;
endpackage

@@ hdl/qubit_gate_state_update_top.sv @@
// Single-qubit gate engine over a 2^n complex amplitude memory.
// An apply visits 2^(n-1) amplitude pairs (controlled: 2^(n-2)); the sequencer steps
// through RD0, RD1, MUL, SUM, WB0 and WB1 for each amplitude pair.
// Front queue holds two commands; the back starts the next one only after the
// single result register has been popped. Sequential, not pipelined.
// Synchronous reset restores the matrix to identity and n to 10; amplitudes undefined.
module qubit_gate_state_update_top #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  qgsu_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output qgsu_pkg::out_item_t out_item,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import qgsu_pkg::*;
  logic [31:0] m00, m01, m10, m11;
  logic [3:0] qubits;
  logic wvalid, wtake;
  work_t work;

  always_ff @(posedge clk) begin
    if (rst) begin
      m00 <= 32'h4000_0000; m01 <= '0; m10 <= '0; m11 <= 32'h4000_0000;
      qubits <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_M00: m00 <= cfg_data;
        REG_M01: m01 <= cfg_data;
        REG_M10: m10 <= cfg_data;
        REG_M11: m11 <= cfg_data;
        REG_QUBIT: qubits <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  qgsu_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
    .clk, .rst, .push, .full, .in_item, .qubits, .wvalid, .wtake, .work
  );

  qgsu_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
    .clk, .rst, .wvalid, .wtake, .work, .qubits, .m00, .m01, .m10, .m11,
    .empty, .pop, .res(out_item)
  );
endmodule

@@ hdl/qgsu_front.sv @@
// Front end: accepts commands, checks arguments, queues classified work.
// Depends on qgsu_pkg.
module qgsu_front #(
  parameter int MAX_QUBITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  qgsu_pkg::in_item_t in_item,
  input  logic [3:0] qubits,
  output logic wvalid,
  input  logic wtake,
  output qgsu_pkg::work_t work
);
  import qgsu_pkg::*;
  localparam int QD = 2;
  work_t q [QD];
  logic [1:0] cnt;
  logic wp, rp;
  logic [4:0] n;
  work_t w;
  logic acc, tk;

  always_comb begin
    n = (qubits == 4'd0) ? 5'd1 :
        ({1'b0, qubits} > 5'(MAX_QUBITS)) ? 5'(MAX_QUBITS) : {1'b0, qubits};
    w = '0;
    w.op = in_item.cmd;
    w.index = 20'(in_item.amp_index);
    w.wr_re = in_item.write_real;
    w.wr_im = in_item.write_imag;
    w.tb = {1'b0, in_item.target_bit};
    w.cb = {1'b0, in_item.control_bit};
    w.ctrl = (in_item.cmd == CMD_CGATE);
    w.status = ST_OK;
    case (in_item.cmd)
      CMD_WRITE, CMD_READ: begin
        if (w.index >= (20'd1 << n)) begin
          w.fail = 1'b1;
          w.status = ST_BAD_IDX;
        end
      end
      default: begin
        if (w.tb >= n || (w.ctrl && (w.cb >= n || w.cb == w.tb))) begin
          w.fail = 1'b1;
          w.status = ST_BAD_QB;
        end
      end
    endcase
  end

  assign full = (cnt == 2'(QD));
  assign acc = push && !full;
  assign wvalid = (cnt != 2'd0);
  assign tk = wtake && wvalid;
  assign work = q[rp];

  always_ff @(posedge clk) begin
    if (acc) q[wp] <= w;
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (acc) wp <= ~wp;
      if (tk) rp <= ~rp;
      cnt <= cnt + 2'(acc) - 2'(tk);
    end
  end
endmodule

@@ hdl/qgsu_back.sv @@
// Back end: amplitude memory and sequencer that applies the 2x2 matrix.
// Depends on qgsu_pkg.
module qgsu_back #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic wvalid,
  output logic wtake,
  input  qgsu_pkg::work_t work,
  input  logic [3:0] qubits,
  input  logic [31:0] m00,
  input  logic [31:0] m01,
  input  logic [31:0] m10,
  input  logic [31:0] m11,
  output logic empty,
  input  logic pop,
  output qgsu_pkg::out_item_t res
);
  import qgsu_pkg::*;
  localparam int AW = MAX_QUBITS;
  localparam int DEPTH = 1 << AW;
  localparam int PW = AW;
  localparam logic signed [AMP_WIDTH-1:0] AMAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AMIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
  localparam int PRW = AMP_WIDTH + 16;
  localparam int SW = PRW + 3;

  typedef enum logic [2:0] {S_IDLE, S_RD0, S_RD1, S_MUL, S_SUM, S_WB0, S_WB1, S_OUT} st_t;
  st_t st;

  logic [2*AMP_WIDTH-1:0] mem0 [DEPTH];
  logic [2*AMP_WIDTH-1:0] rd;
  logic signed [AMP_WIDTH-1:0] rdr, rdi;
  logic [AW-1:0] raddr, waddr;
  logic [2*AMP_WIDTH-1:0] wdata;
  logic we;

  work_t cur;
  logic [PW:0] pc;
  logic [AW-1:0] i0, i1;
  logic signed [AMP_WIDTH-1:0] v0r, v0i, v1r, v1i;
  logic signed [PRW-1:0] p [8];
  logic signed [AMP_WIDTH-1:0] o0r, o0i, o1r, o1i;
  logic [4:0] n;
  logic [PW:0] npairs;
  logic out_full;
  out_item_t ob;

  // memory
  always_ff @(posedge clk) begin
    if (we) mem0[waddr] <= wdata;
    rd <= mem0[raddr];
  end

  function automatic logic signed [AMP_WIDTH-1:0] sat16w(input logic signed [15:0] x);
    logic signed [AMP_WIDTH+15:0] e;
    e = (AMP_WIDTH+16)'(x);
    if (e > (AMP_WIDTH+16)'(AMAX)) return AMAX;
    if (e < (AMP_WIDTH+16)'(AMIN)) return AMIN;
    return AMP_WIDTH'(e);
  endfunction

  function automatic logic signed [15:0] sat_rd(input logic signed [AMP_WIDTH-1:0] x);
    logic signed [AMP_WIDTH+15:0] e;
    e = (AMP_WIDTH+16)'(x);
    if (e > 32'sd32767) return 16'sh7fff;
    if (e < -32'sd32768) return 16'sh8000;
    return 16'(e);
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [PRW-1:0] x);
    logic signed [PRW:0] v;
    v = (PRW+1)'(x) + (PRW+1)'(8192);
    return SW'(v >>> 14);
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] satw(input logic signed [SW-1:0] x);
    if (x > SW'(AMAX)) return AMAX;
    if (x < SW'(AMIN)) return AMIN;
    return AMP_WIDTH'(x);
  endfunction

  // insert a zero at bit position b
  function automatic logic [AW-1:0] ins0(input logic [AW-1:0] x, input logic [4:0] b);
    logic [AW-1:0] m;
    m = (AW'(1) << b) - AW'(1);
    return ((x & ~m) << 1) | (x & m);
  endfunction

  // pair index: insert zero at target bit (and control bit), force control bit
  function automatic logic [AW-1:0] pidx(input logic [PW:0] k, input logic [4:0] tb,
                                         input logic [4:0] cb, input logic c);
    logic [AW-1:0] km, r;
    km = AW'(k);
    if (c) begin
      if (tb < cb) r = ins0(ins0(km, tb), cb);
      else r = ins0(ins0(km, cb), tb);
      r = r | (AW'(1) << cb);
    end else begin
      r = ins0(km, tb);
    end
    return r;
  endfunction

  logic signed [15:0] ar, ai, br, bi, cr, ci, dr, di;
  assign ar = m00[31:16]; assign ai = m00[15:0];
  assign br = m01[31:16]; assign bi = m01[15:0];
  assign cr = m10[31:16]; assign ci = m10[15:0];
  assign dr = m11[31:16]; assign di = m11[15:0];

  assign rdr = rd[2*AMP_WIDTH-1:AMP_WIDTH];
  assign rdi = rd[AMP_WIDTH-1:0];

  assign n = (qubits == 4'd0) ? 5'd1 :
             ({1'b0, qubits} > 5'(MAX_QUBITS)) ? 5'(MAX_QUBITS) : {1'b0, qubits};
  assign npairs = (PW+1)'(1) << (n - 5'd1);
  assign i0 = pidx(pc, cur.tb, cur.cb, cur.ctrl);
  assign i1 = i0 | (AW'(1) << cur.tb);
  assign empty = !out_full;
  assign res = ob;
  assign wtake = (st == S_IDLE) && wvalid && !out_full;

  always_comb begin
    we = 1'b0;
    waddr = cur.index[AW-1:0];
    wdata = {sat16w(cur.wr_re), sat16w(cur.wr_im)};
    raddr = i0;
    case (st)
      S_IDLE: begin
        raddr = work.index[AW-1:0];
        if (wtake && !work.fail && work.op == CMD_WRITE) begin
          we = 1'b1;
          waddr = work.index[AW-1:0];
          wdata = {sat16w(work.wr_re), sat16w(work.wr_im)};
        end
      end
      S_RD1: raddr = i1;
      S_WB0: begin
        we = 1'b1; waddr = i0; wdata = {o0r, o0i};
      end
      S_WB1: begin
        we = 1'b1; waddr = i1; wdata = {o1r, o1i};
      end
      default: raddr = i0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (wtake) begin
            cur <= work;
            pc <= '0;
            if (work.fail || work.op == CMD_WRITE) begin
              ob <= '{16'sd0, 16'sd0, work.status};
              out_full <= 1'b1;
            end else if (work.op == CMD_READ) begin
              st <= S_OUT;
            end else begin
              st <= S_RD0;
            end
          end
        end
        S_OUT: begin
          ob <= '{sat_rd(rd[2*AMP_WIDTH-1:AMP_WIDTH]), sat_rd(rd[AMP_WIDTH-1:0]), ST_OK};
          out_full <= 1'b1;
          st <= S_IDLE;
        end
        S_RD0: st <= S_RD1;
        S_RD1: begin
          v0r <= rdr;
          v0i <= rdi;
          st <= S_MUL;
        end
        S_MUL: begin
          v1r <= rdr;
          v1i <= rdi;
          p[0] <= ar * v0r;     p[1] <= ai * v0i;
          p[2] <= br * rdr;     p[3] <= bi * rdi;
          p[4] <= ar * v0i;     p[5] <= ai * v0r;
          p[6] <= br * rdi;     p[7] <= bi * rdr;
          st <= S_SUM;
        end
        S_SUM: begin
          o0r <= satw(rnd(p[0]) - rnd(p[1]) + rnd(p[2]) - rnd(p[3]));
          o0i <= satw(rnd(p[4]) + rnd(p[5]) + rnd(p[6]) + rnd(p[7]));
          p[0] <= cr * v0r; p[1] <= ci * v0i;
          p[2] <= dr * v1r; p[3] <= di * v1i;
          p[4] <= cr * v0i; p[5] <= ci * v0r;
          p[6] <= dr * v1i; p[7] <= di * v1r;
          st <= S_WB0;
        end
        S_WB0: begin
          o1r <= satw(rnd(p[0]) - rnd(p[1]) + rnd(p[2]) - rnd(p[3]));
          o1i <= satw(rnd(p[4]) + rnd(p[5]) + rnd(p[6]) + rnd(p[7]));
          st <= S_WB1;
        end
        S_WB1: begin
          if ((cur.ctrl ? pc + (PW+1)'(1) >= (npairs >> 1) : pc + (PW+1)'(1) >= npairs)) begin
            ob <= '{16'sd0, 16'sd0, ST_OK};
            out_full <= 1'b1;
            st <= S_IDLE;
          end else begin
            pc <= pc + (PW+1)'(1);
            st <= S_RD0;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ test/qubit_gate_state_update_top_test.sv @@
// Testbench for qubit_gate_state_update_top: random and directed commands over several
// gate matrices and qubit counts, checked against an in-bench state vector predictor.
// Depends on qgsu_pkg and the top module only.
`timescale 1ns / 1ps

class gate_tracker;
  logic signed [15:0] amp_re [1024];
  logic signed [15:0] amp_im [1024];
  bit                 written [1024];
  logic [31:0]        mat [4];
  logic [3:0]         qubits;
  qgsu_pkg::out_item_t expected_results [$];
  int errors;
  int checked;

  function new();
    mat[0] = 32'h4000_0000;
    mat[1] = '0;
    mat[2] = '0;
    mat[3] = 32'h4000_0000;
    qubits = 4'd10;
    errors = 0;
    checked = 0;
    foreach (written[i]) begin
      written[i] = 1'b0;
      amp_re[i] = '0;
      amp_im[i] = '0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    if (idx < qgsu_pkg::REG_QUBIT) mat[idx] = val;
    else if (idx == qgsu_pkg::REG_QUBIT) qubits = val[3:0];
  endfunction

  function int active_n();
    if (qubits < 1) return 1;
    if (qubits > 10) return 10;
    return qubits;
  endfunction

  function bit args_ok(qgsu_pkg::in_item_t it);
    int n;
    n = active_n();
    if (it.target_bit >= n) return 0;
    if (it.cmd == qgsu_pkg::CMD_CGATE && (it.control_bit >= n || it.control_bit == it.target_bit))
      return 0;
    return 1;
  endfunction

  // first unwritten entry inside the active length, -1 if none
  function int first_unwritten();
    for (int i = 0; i < (1 << active_n()); i++) if (!written[i]) return i;
    return -1;
  endfunction

  function longint rnd(longint p);
    return (p + 8192) >>> 14;
  endfunction

  function logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function void mix(logic [31:0] ma, logic [31:0] mb, longint v0r, longint v0i,
                    longint v1r, longint v1i, output logic signed [15:0] orr,
                    output logic signed [15:0] oi);
    longint ar, ai, br, bi;
    ar = longint'($signed(ma[31:16]));
    ai = longint'($signed(ma[15:0]));
    br = longint'($signed(mb[31:16]));
    bi = longint'($signed(mb[15:0]));
    orr = sat16(rnd(ar * v0r) - rnd(ai * v0i) + rnd(br * v1r) - rnd(bi * v1i));
    oi  = sat16(rnd(ar * v0i) + rnd(ai * v0r) + rnd(br * v1i) + rnd(bi * v1r));
  endfunction

  function void note_push(qgsu_pkg::in_item_t it);
    qgsu_pkg::out_item_t res;
    int len, t, c, j;
    longint v0r, v0i, v1r, v1i;
    len = 1 << active_n();
    res = '0;
    res.status = qgsu_pkg::ST_OK;
    if (it.cmd == qgsu_pkg::CMD_WRITE || it.cmd == qgsu_pkg::CMD_READ) begin
      if (it.amp_index >= len) begin
        res.status = qgsu_pkg::ST_BAD_IDX;
      end else if (it.cmd == qgsu_pkg::CMD_WRITE) begin
        amp_re[it.amp_index] = it.write_real;
        amp_im[it.amp_index] = it.write_imag;
        written[it.amp_index] = 1'b1;
      end else begin
        res.read_real = amp_re[it.amp_index];
        res.read_imag = amp_im[it.amp_index];
      end
    end else if (!args_ok(it)) begin
      res.status = qgsu_pkg::ST_BAD_QB;
    end else begin
      t = 1 << it.target_bit;
      c = (it.cmd == qgsu_pkg::CMD_CGATE) ? (1 << it.control_bit) : 0;
      for (int i = 0; i < len; i++) begin
        if ((i & t) == 0 && (i & c) == c) begin
          j = i | t;
          v0r = amp_re[i];
          v0i = amp_im[i];
          v1r = amp_re[j];
          v1i = amp_im[j];
          mix(mat[0], mat[1], v0r, v0i, v1r, v1i, amp_re[i], amp_im[i]);
          mix(mat[2], mat[3], v0r, v0i, v1r, v1i, amp_re[j], amp_im[j]);
        end
      end
    end
    expected_results.push_back(res);
  endfunction

  function void check_pop(qgsu_pkg::out_item_t got);
    qgsu_pkg::out_item_t exp_res;
    if (expected_results.size() == 0) begin
      $error("unexpected result transfer: %h", got);
      errors++;
      return;
    end
    exp_res = expected_results.pop_front();
    checked++;
    if (got.read_real !== exp_res.read_real) begin
      $error("read_real expected %0d actual %0d", exp_res.read_real, got.read_real);
      errors++;
    end
    if (got.read_imag !== exp_res.read_imag) begin
      $error("read_imag expected %0d actual %0d", exp_res.read_imag, got.read_imag);
      errors++;
    end
    if (got.status !== exp_res.status) begin
      $error("status expected %0d actual %0d", exp_res.status, got.status);
      errors++;
    end
  endfunction
endclass

module qubit_gate_state_update_top_test;
  import qgsu_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  in_item_t in_item = '0;
  out_item_t out_item;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gate_tracker sb = new();
  int idle_cycles = 0;
  int pushed = 0;
  int popped = 0;
  int applies_done = 0;

  qubit_gate_state_update_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 30000) begin
      $display("timeout with %0d results outstanding", sb.expected_results.size());
      $display("qubit_gate_state_update_top regression: fail");
      $finish;
    end
  end

  // receiver, with one long hold-off to fill the block
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (popped == 60) gap = 400;
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      sb.check_pop(out_item);
      popped++;
    end
  end

  task automatic send(in_item_t it, int gap);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_push(it);
    pushed++;
    if ((it.cmd == CMD_GATE || it.cmd == CMD_CGATE) && sb.args_ok(it)) applies_done++;
  endtask

  task automatic drain();
    push <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  function automatic in_item_t mk(cmd_t c, int idx, int re, int im, int tb, int cb);
    in_item_t it;
    it.cmd = c;
    it.amp_index = 10'(idx);
    it.write_real = 16'(re);
    it.write_imag = 16'(im);
    it.target_bit = 4'(tb);
    it.control_bit = 4'(cb);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r, len, u;
    len = 1 << sb.active_n();
    it = ($bits(in_item_t))'({$urandom, $urandom});
    r = $urandom_range(0, 9);
    it.cmd = (r < 4) ? CMD_WRITE : (r < 6) ? CMD_READ : (r < 8) ? CMD_GATE : CMD_CGATE;
    if ($urandom_range(0, 4) != 0) it.amp_index = 10'($urandom_range(0, len - 1));
    if ($urandom_range(0, 4) != 0) it.target_bit = 4'($urandom_range(0, sb.active_n() - 1));
    if ($urandom_range(0, 4) != 0) it.control_bit = 4'($urandom_range(0, sb.active_n() - 1));
    // never read an entry that has not been written, nor apply a gate while one is unwritten
    if (it.cmd == CMD_READ && it.amp_index < len && !sb.written[it.amp_index])
      it.cmd = CMD_WRITE;
    if ((it.cmd == CMD_GATE || it.cmd == CMD_CGATE) && sb.args_ok(it)) begin
      u = sb.first_unwritten();
      if (u >= 0) begin
        it.cmd = CMD_WRITE;
        it.amp_index = 10'(u);
      end
    end
    return it;
  endfunction

  function automatic logic [31:0] random_entry();
    case ($urandom_range(0, 7))
      0: return 32'hffff_ffff;
      1: return 32'h8000_8000;
      2: return 32'h7fff_7fff;
      3: return 32'h2d41_0000;
      4: return 32'hd2bf_0000;
      5: return 32'h0000_4000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int qubit_plan [10];
    int g;
    qubit_plan = '{1, 0, 3, 2, 5, 4, 15, 1, 3, 2};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset state, extremes, bad index / qubit arguments
    send(mk(CMD_WRITE, 0, 16'h7fff, 16'h8000, 0, 0), 0);
    send(mk(CMD_WRITE, 1023, 16'h8000, 16'h7fff, 0, 0), 0);
    send(mk(CMD_READ, 0, 0, 0, 0, 0), 0);
    send(mk(CMD_READ, 1023, 0, 0, 0, 0), 2);
    send(mk(CMD_GATE, 0, 0, 0, 10, 0), 0);
    send(mk(CMD_GATE, 0, 0, 0, 15, 0), 0);
    send(mk(CMD_CGATE, 0, 0, 0, 3, 3), 0);
    send(mk(CMD_CGATE, 0, 0, 0, 2, 15), 1);
    drain();
    write_reg(REG_QUBIT, 1);
    send(mk(CMD_WRITE, 0, 16'h4000, 16'h0000, 0, 0), 0);
    send(mk(CMD_WRITE, 1, 16'h8000, 16'hffff, 0, 0), 0);
    send(mk(CMD_WRITE, 2, 16'h1234, 16'h1234, 0, 0), 0);
    send(mk(CMD_READ, 1023, 0, 0, 0, 0), 0);
    send(mk(CMD_GATE, 0, 0, 0, 0, 0), 0);
    send(mk(CMD_GATE, 0, 0, 0, 1, 0), 0);
    send(mk(CMD_CGATE, 0, 0, 0, 0, 1), 0);
    send(mk(CMD_READ, 1, 0, 0, 0, 0), 0);
    drain();
    write_reg(REG_M00, 32'h7fff_7fff);
    write_reg(REG_M01, 32'h7fff_7fff);
    write_reg(REG_M10, 32'h8000_8000);
    write_reg(REG_M11, 32'hffff_ffff);
    send(mk(CMD_GATE, 0, 0, 0, 0, 0), 0);
    send(mk(CMD_READ, 0, 0, 0, 0, 0), 0);
    send(mk(CMD_READ, 1, 0, 0, 0, 0), 0);
    drain();

    foreach (qubit_plan[p]) begin
      write_reg(REG_M00, random_entry());
      write_reg(REG_M01, random_entry());
      write_reg(REG_M10, random_entry());
      write_reg(REG_M11, random_entry());
      write_reg(REG_QUBIT, qubit_plan[p]);
      for (int k = 0; k < 115; k++) begin
        g = $urandom_range(0, 17);
        if (p % 3 == 1 || $urandom_range(0, 2) == 0) g = 0;
        send(random_item(), g);
      end
      drain();
    end

    $display("%0d commands sent, %0d results checked, %0d gate applications",
             pushed, sb.checked, applies_done);
    $display("qubit counts 0 to 15 with saturating and identity-like matrices");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("qubit_gate_state_update_top regression: pass");
    end else begin
      $display("qubit_gate_state_update_top regression: fail");
    end
    $finish;
  end
endmodule
